/* rtl/core/bxavg_pkg.sv */
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared constants, register indexes and helpers for the box-average
// image downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

    // default line and frame limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // field widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 8;
    localparam int PIX_W     = 32;
    localparam int SUM_W     = 56;
    localparam int CNT_W     = 25;
    localparam int COORD_W   = 12;
    localparam int OUT_W     = PIX_W + 2 * COORD_W;

    // reset values of the size registers
    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd1024;
    localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 13'd512;
    localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 13'd512;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    // clamp a size to [1, hi]
    function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v,
                                                    logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = {{(CFG_W-1){1'b0}}, 1'b1};
        else if (v > hi)
            r = hi;
        return r;
    endfunction

endpackage

/* rtl/core/box_average_image_downscale_top.sv */
// ----------------------------------------------------------------------------
// box_average_image_downscale_top
// Area-average downscaler: source pixels in raster order, one averaged
// pixel out per destination box.
// ----------------------------------------------------------------------------
// Each source pixel is a read-modify-write of one line-buffer entry (sum and
// count per destination column). A pixel that closes a destination box also
// runs the bit-serial divider and then hands the result to the output
// register. If the previous average still sits in the output register at
// that point, the block holds until the receiver takes it. After reset and
// after every write to a size register the line buffer is swept to zero; no
// pixel is accepted during the sweep, and that write also restarts the
// frame. A finished average waits in the output register while further
// pixels are taken.
module box_average_image_downscale_top #(
    parameter int MAX_WIDTH  = bxavg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bxavg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bxavg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bxavg_pkg::CFG_W-1:0]    cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bxavg_pkg::PIX_W-1:0]    s_axis_tdata,   // pixel_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bxavg_pkg::OUT_W-1:0]    m_axis_tdata,   // avg_value, out_col, out_row
    output logic                           m_axis_tlast    // frame_end
);

    import bxavg_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int MW = SUM_W + CNT_W;
    localparam logic [CFG_W-1:0] HI_W = (MAX_WIDTH  > 8191) ? 13'h1FFF : CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HI_H = (MAX_HEIGHT > 8191) ? 13'h1FFF : CFG_W'(MAX_HEIGHT);
    localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_WIDTH - 1);
    localparam logic [5:0]       DIV_LAST = 6'(SUM_W - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [AW-1:0]      clr_reg;
    logic [CFG_W-1:0]   cx_reg, cy_reg, xacc_reg, yacc_reg, dr_reg;
    logic [AW-1:0]      dc_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [SUM_W-1:0]   q_reg;
    logic [CNT_W-1:0]   rem_reg, div_cnt_reg;
    logic               neg_reg;
    logic [5:0]         step_reg;
    logic [AW-1:0]      res_col_reg;
    logic [CFG_W-1:0]   res_row_reg;
    logic               res_last_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_last_reg;

    logic [CFG_W-1:0]   sw, sh, dw, dh;
    logic [CFG_W:0]     xacc_sum, yacc_sum;
    logic               last_x, last_y, end_col, end_row, emit;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [MW-1:0]      ram_wdata, ram_rdata;
    logic [SUM_W-1:0]   new_sum, mag;
    logic [CNT_W-1:0]   new_cnt;
    logic [CNT_W:0]     trial;
    logic [PIX_W-1:0]   quo, avg;
    logic               cfg_hit;

    // effective sizes
    assign sw = clamp_size(src_w_reg, HI_W);
    assign sh = clamp_size(src_h_reg, HI_H);
    assign dw = clamp_size(dst_w_reg, sw);
    assign dh = clamp_size(dst_h_reg, sh);

    // box boundaries from the running column and row remainders
    assign xacc_sum = {1'b0, xacc_reg} + {1'b0, dw};
    assign yacc_sum = {1'b0, yacc_reg} + {1'b0, dh};
    assign end_col  = ({1'b0, cx_reg} + 14'd1) >= {1'b0, sw};
    assign end_row  = ({1'b0, cy_reg} + 14'd1) >= {1'b0, sh};
    assign last_x   = end_col || (xacc_sum >= {1'b0, sw});
    assign last_y   = end_row || (yacc_sum >= {1'b0, sh});
    assign emit     = last_x && last_y;

    // line buffer update
    assign new_sum = ram_rdata[SUM_W-1:0] + {{(SUM_W-PIX_W){pix_reg[PIX_W-1]}}, pix_reg};
    assign new_cnt = ram_rdata[MW-1:SUM_W] + CNT_W'(1);
    assign mag     = new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = dc_reg;
        ram_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            ST_RMW:
            begin
                ram_we    = 1'b1;
                ram_wdata = emit ? '0 : {new_cnt, new_sum};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    bxavg_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // divider step and signed result
    assign trial = {rem_reg, q_reg[SUM_W-1]} - {1'b0, div_cnt_reg};
    assign quo   = q_reg[PIX_W-1:0];
    assign avg   = (div_cnt_reg == '0) ? '0 : (neg_reg ? (~quo + PIX_W'(1)) : quo);

    assign cfg_hit = cfg_we && (cfg_index[CFG_IDX_W-1:2] == '0);

    // control, position tracking, divider and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            src_w_reg     <= RST_SRC_WIDTH;
            src_h_reg     <= RST_SRC_HEIGHT;
            dst_w_reg     <= RST_DST_WIDTH;
            dst_h_reg     <= RST_DST_HEIGHT;
            clr_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            xacc_reg      <= '0;
            yacc_reg      <= '0;
            dc_reg        <= '0;
            dr_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output register load and hand-off
            if ((state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {COORD_W'(res_row_reg), COORD_W'(res_col_reg), avg};
                out_last_reg  <= res_last_reg;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            // size register writes restart the frame
            if (cfg_hit)
            begin
                case (cfg_reg_t'(cfg_index[1:0]))
                    REG_SRC_WIDTH:  src_w_reg <= cfg_data;
                    REG_SRC_HEIGHT: src_h_reg <= cfg_data;
                    REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                    REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                    default:        src_w_reg <= src_w_reg;
                endcase
                state_reg <= ST_CLEAR;
                clr_reg   <= '0;
                cx_reg    <= '0;
                cy_reg    <= '0;
                xacc_reg  <= '0;
                yacc_reg  <= '0;
                dc_reg    <= '0;
                dr_reg    <= '0;
            end
            else
            begin
                case (state_reg)
                    ST_CLEAR:
                    begin
                        clr_reg <= clr_reg + AW'(1);
                        if (clr_reg == CLR_LAST)
                            state_reg <= ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        if (s_axis_tvalid)
                        begin
                            pix_reg   <= s_axis_tdata;
                            state_reg <= ST_RMW;
                        end
                    end
                    ST_RMW:
                    begin
                        state_reg <= emit ? ST_DIV : ST_IDLE;
                        if (emit)
                        begin
                            neg_reg      <= new_sum[SUM_W-1];
                            q_reg        <= mag;
                            rem_reg      <= '0;
                            div_cnt_reg  <= new_cnt;
                            step_reg     <= '0;
                            res_col_reg  <= dc_reg;
                            res_row_reg  <= dr_reg;
                            res_last_reg <= (32'(dc_reg) == 32'(dw) - 1)
                                            && (dr_reg == dh - 13'd1);
                        end
                        // advance the source position
                        if (end_col)
                        begin
                            cx_reg   <= '0;
                            xacc_reg <= '0;
                            dc_reg   <= '0;
                            if (end_row)
                            begin
                                cy_reg   <= '0;
                                yacc_reg <= '0;
                                dr_reg   <= '0;
                            end
                            else
                            begin
                                cy_reg <= cy_reg + 13'd1;
                                if (yacc_sum >= {1'b0, sh})
                                begin
                                    yacc_reg <= CFG_W'(yacc_sum - {1'b0, sh});
                                    dr_reg   <= dr_reg + 13'd1;
                                end
                                else
                                    yacc_reg <= CFG_W'(yacc_sum);
                            end
                        end
                        else
                        begin
                            cx_reg <= cx_reg + 13'd1;
                            if (xacc_sum >= {1'b0, sw})
                            begin
                                xacc_reg <= CFG_W'(xacc_sum - {1'b0, sw});
                                dc_reg   <= dc_reg + AW'(1);
                            end
                            else
                                xacc_reg <= CFG_W'(xacc_sum);
                        end
                    end
                    ST_DIV:
                    begin
                        if (!trial[CNT_W])
                        begin
                            rem_reg <= trial[CNT_W-1:0];
                            q_reg   <= {q_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[CNT_W-2:0], q_reg[SUM_W-1]};
                            q_reg   <= {q_reg[SUM_W-2:0], 1'b0};
                        end
                        step_reg <= step_reg + 6'd1;
                        if (step_reg == DIV_LAST)
                            state_reg <= ST_DONE;
                    end
                    ST_DONE:
                    begin
                        if (!out_valid_reg || m_axis_tready)
                            state_reg <= ST_IDLE;
                    end
                    default:
                    begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // write-back goes to the entry that was just read
    a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW) |-> (ram_addr == $past(ram_addr)))
        else $error("line buffer write-back address differs from read address");

    // source column stays inside the source width
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cx_reg < sw))
        else $error("source column beyond source width");

    // divider always completes before the result is handed over
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (step_reg == DIV_LAST + 6'd1))
        else $error("result taken before divider finished");

endmodule

/* rtl/core/bxavg_ram.sv */
// ----------------------------------------------------------------------------
// bxavg_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bxavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule
